### sv/positional_array_list_macros.svh
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, held off while in reset
`define PAL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while in reset
`define PAL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/pal_pkg.sv
package pal_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int ST_W  = 3;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam int IN_BITS  = OP_W + POS_W + DATA_WIDTH;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ST_W + POS_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ENC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

### sv/pal_ctrl.sv
module pal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pal_pkg::dp_status_t stat,
  output pal_pkg::ctrl_cmd_t  cmd
);
  import pal_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_ENC;
      end
      S_ENC: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### sv/pal_dpath.sv
module pal_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pal_pkg::IN_W-1:0]     in_tdata,
  input  pal_pkg::ctrl_cmd_t           cmd,
  output pal_pkg::dp_status_t          stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pal_pkg::OUT_W-1:0]    out_tdata
);
  import pal_pkg::*;

  logic [OP_W-1:0]       op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] word_r;

  logic [DATA_WIDTH-1:0] entries_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_nxt [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_up      [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_dn      [CAPACITY];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ST_W-1:0]     stat_r, stat_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_data_r, out_data_nxt;

  logic [CMP_W-1:0] pos_c, cnt_c, p0_c;
  logic             ins_ok, ins_range, ins_full;
  logic             ers_ok, ers_empty, ers_range;
  logic [POS_W-1:0] found_pos;
  logic [ST_W-1:0]  res_stat;

  assign pos_c = CMP_W'(pos_r);
  assign cnt_c = CMP_W'(count_r);
  assign p0_c  = pos_c - CMP_W'(1);

  assign ins_range = (pos_c == '0) || (pos_c > cnt_c + CMP_W'(1));
  assign ins_full  = (cnt_c >= CMP_W'(CAPACITY));
  assign ins_ok    = (op_r == OP_INSERT) && !ins_range && !ins_full;
  assign ers_empty = (count_r == '0);
  assign ers_range = (pos_c == '0) || (pos_c > cnt_c);
  assign ers_ok    = (op_r == OP_ERASE) && !ers_empty && !ers_range;

  always_comb begin
    ent_up[0]          = entries_r[0];
    ent_dn[CAPACITY-1] = entries_r[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      ent_up[i] = entries_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      ent_dn[i] = entries_r[i+1];
    end
  end

  always_comb begin
    count_nxt = count_r;
    stat_nxt  = ST_OK;
    match_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
      match_nxt[i]   = (entries_r[i] == word_r) && (CMP_W'(i) < cnt_c);
      if (ins_ok && CMP_W'(i) >= p0_c) begin
        entries_nxt[i] = (CMP_W'(i) == p0_c) ? word_r : ent_up[i];
      end
      if (ers_ok && CMP_W'(i) >= p0_c) begin
        entries_nxt[i] = ent_dn[i];
      end
    end
    case (op_r)
      OP_INSERT: begin
        if (ins_range) begin
          stat_nxt = ST_RANGE;
        end else if (ins_full) begin
          stat_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (ers_empty) begin
          stat_nxt = ST_EMPTY;
        end else if (ers_range) begin
          stat_nxt = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        stat_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    found_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found_pos = POS_W'(i + 1);
      end
    end
    if (op_r == OP_FIND) begin
      res_stat = (match_r != '0) ? ST_OK : ST_NOTFOUND;
    end else begin
      res_stat  = stat_r;
      found_pos = '0;
    end
  end

  assign out_data_nxt  = {count_r, found_pos, res_stat};
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tdata[OP_W-1:0];
      pos_r  <= in_tdata[OP_W +: POS_W];
      word_r <= in_tdata[OP_W+POS_W +: DATA_WIDTH];
    end
    if (cmd.exec) begin
      stat_r  <= stat_nxt;
      match_r <= match_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = OUT_W'(out_data_r);

endmodule

### sv/positional_array_list.sv
// Each operation passes through capture, execute and encode steps, in that order.
// Each op runs alone through the shift-register cells, then a registered encode
// stage forms the result beat once the output is free.
// A new beat is taken while an earlier result still waits on out_tready.
// Reset (rst_n low, synchronous): list emptied and output beat dropped.
module positional_array_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // op [1:0], position [6:2], value [38:7], zero fill
  input  logic [pal_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status [2:0], found_position [7:3], entry_count [12:8], zero fill
  output logic [pal_pkg::OUT_W-1:0] out_tdata
);
  import pal_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pal_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sv/pal_checker.sv
`include "positional_array_list_macros.svh"

module pal_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [pal_pkg::OUT_W-1:0] out_tdata
);
  import pal_pkg::*;

  `PAL_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PAL_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PAL_ASSERT_IMP(a_fail_no_pos, clk, rst_n, out_tvalid && (out_tdata[2:0] != ST_OK), out_tdata[7:3] == '0)
  `PAL_ASSERT_IMP(a_count_cap, clk, rst_n, out_tvalid, out_tdata[12:8] <= CNT_W'(CAPACITY))

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
